// ===== rtl/core/tha_pkg.sv =====
// Shared constants, tables and types for the trace heading pipeline.
// No dependencies; every module imports this package.
package tha_pkg;

    localparam int MAX_STEP = 16;
    localparam int STEP_W   = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int FILL_W   = $clog2(MAX_STEP + 1);
    localparam int CFG_W    = 5;
    localparam int LON_W    = 31;
    localparam int LAT_W    = 30;
    localparam int HEAD_W   = 31;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int ROT_STEPS = 24;
    localparam int ROT_LAT   = ROT_STEPS + 1;
    localparam int ISQ_STEPS = 31;
    localparam int ISQ_LAT   = ISQ_STEPS + 1;
    localparam int DIV_STEPS = 30;

    localparam logic signed [33:0] DEG90  = 34'sd377487360;
    localparam logic signed [33:0] DEG180 = 34'sd754974720;
    localparam logic signed [33:0] DEG360 = 34'sd1509949440;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [60:0] ONE_SQ = 61'd1 << 60;

    // atan(2^-i) in degrees times 2^22
    localparam logic signed [31:0] ATAN_TAB [ROT_STEPS] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    typedef enum logic [1:0] {
        QD_NE    = 2'd0,
        QD_NW    = 2'd1,
        QD_OTHER = 2'd2
    } t_quad;

    typedef struct packed {
        logic signed [LON_W-1:0] lona;
        logic signed [LAT_W-1:0] lata;
        logic signed [LON_W-1:0] lonb;
        logic signed [LAT_W-1:0] latb;
        t_quad                   quad;
        logic                    same;
    } t_item;

    typedef struct packed {
        t_quad quad;
        logic  same;
        logic  zero;
        logic  sat;
        logic  neg;
    } t_tag;

endpackage

// ===== rtl/core/trace_heading_azimuth.sv =====
// Top level of the trace heading block: config register, front end, queue, back end.
// Depends on tha_pkg, tha_front, tha_queue and tha_back.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+----------------------
//  s_axis   | in  | tdata: longitude, latitude; tuser: trace_start | tvalid/tready
//  m_axis   | out | tdata: heading; tuser: degenerate             | tvalid/tready
//  cfg      | in  | i_cfg_wdata: step_distance                    | i_cfg_we, no wait
//
// One word per cycle in and out when the sink keeps up. After a word leaves the
// queue, its result passes through the two square-root pipelines, the 30-step
// divider and the rotation and vectoring CORDIC chains.
// The back end stalls as one piece when the output register is held; the queue
// keeps taking words until it is full, then tready drops.
// Reset (synchronous, active low) clears fill count, queue and valid bits and sets
// step_distance to 1; the delay line itself is not cleared.
module trace_heading_azimuth
    import tha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // [30:0] longitude, [60:31] latitude, pad
    input  logic [0:0]       s_axis_tuser,   // [0] trace_start
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [30:0] heading, pad
    output logic [0:0]       m_axis_tuser,   // [0] degenerate
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0]  r_step_dist;
    logic              acc;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_item             item;
    t_item             head;
    logic [HEAD_W-1:0] heading;

    // step_distance, to be written by the user only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_dist <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_step_dist <= i_cfg_wdata;
        end
    end

    // accept whenever the queue has room; pairs with no result are simply dropped
    assign s_axis_tready = !full;
    assign acc           = s_axis_tvalid && s_axis_tready;

    tha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_start (s_axis_tuser[0]),
        .i_lon   ($signed(s_axis_tdata[LON_W-1:0])),
        .i_lat   ($signed(s_axis_tdata[LON_W+LAT_W-1:LON_W])),
        .i_step  (r_step_dist),
        .o_push  (push),
        .o_item  (item)
    );

    tha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    tha_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_head    (head),
        .o_pop     (pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_heading (heading),
        .o_degen   (m_axis_tuser[0])
    );

    assign m_axis_tdata = {1'b0, heading};

endmodule

// ===== rtl/core/tha_front.sv =====
// Front end: position delay line, fill tracking and pair classification.
// Depends on tha_pkg.
module tha_front
    import tha_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_acc,
    input  logic                    i_start,
    input  logic signed [LON_W-1:0] i_lon,
    input  logic signed [LAT_W-1:0] i_lat,
    input  logic [CFG_W-1:0]        i_step,
    output logic                    o_push,
    output t_item                   o_item
);

    logic signed [LON_W-1:0] r_lon [MAX_STEP];
    logic signed [LAT_W-1:0] r_lat [MAX_STEP];
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic [FILL_W-1:0]       eff_fill;
    logic [FILL_W-1:0]       step_eff;
    logic [STEP_W-1:0]       idx;

    always_comb begin
        if (i_step == '0) begin
            step_eff = FILL_W'(1);
        end else if (int'(i_step) > MAX_STEP) begin
            step_eff = FILL_W'(MAX_STEP);
        end else begin
            step_eff = FILL_W'(i_step);
        end
        idx      = STEP_W'(step_eff - 1'b1);
        eff_fill = i_start ? '0 : r_fill;
        n_fill   = (int'(eff_fill) >= MAX_STEP) ? eff_fill : eff_fill + 1'b1;
    end

    always_comb begin
        o_item.lona = r_lon[idx];
        o_item.lata = r_lat[idx];
        o_item.lonb = i_lon;
        o_item.latb = i_lat;
        o_item.same = (i_lon == r_lon[idx]) && (i_lat == r_lat[idx]);
        if (i_lon > r_lon[idx] && i_lat > r_lat[idx]) begin
            o_item.quad = QD_NE;
        end else if (i_lon < r_lon[idx] && i_lat > r_lat[idx]) begin
            o_item.quad = QD_NW;
        end else begin
            o_item.quad = QD_OTHER;
        end
    end

    assign o_push = i_acc && (eff_fill >= step_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_acc) begin
            r_fill <= n_fill;
        end
    end

    // shift the new point in at the head, oldest falls off the tail
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_lon[0] <= i_lon;
            r_lat[0] <= i_lat;
        end
    end

    for (genvar k = 1; k < MAX_STEP; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (i_acc) begin
                r_lon[k] <= r_lon[k-1];
                r_lat[k] <= r_lat[k-1];
            end
        end
    end

endmodule

// ===== rtl/core/tha_queue.sv =====
// Short queue of point pairs between front end and arithmetic back end.
// Depends on tha_pkg.
module tha_queue
    import tha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/tha_rot.sv =====
// Pipelined rotation CORDIC: sine and cosine of an angle in degrees * 2^22.
// Depends on tha_pkg; one iteration per stage.
module tha_rot
    import tha_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_ang,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    logic signed [33:0] wr;
    logic signed [33:0] fz;
    logic               fl;
    logic signed [31:0] r_x [ROT_LAT];
    logic signed [31:0] r_y [ROT_LAT];
    logic signed [31:0] r_z [ROT_STEPS];
    logic               r_f [ROT_STEPS];

    // reduce into (-180, 180], then fold into [-90, 90]
    always_comb begin
        wr = i_ang;
        if (i_ang > DEG180) begin
            wr = i_ang - DEG360;
        end else if (i_ang <= -DEG180) begin
            wr = i_ang + DEG360;
        end
        fz = wr;
        fl = 1'b0;
        if (wr > DEG90) begin
            fz = DEG180 - wr;
            fl = 1'b1;
        end else if (wr < -DEG90) begin
            fz = -DEG180 - wr;
            fl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= 32'(fz);
            r_f[0] <= fl;
        end
    end

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_it
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [31:0] n_z;
        always_comb begin
            if (r_z[i] >= 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATAN_TAB[i];
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATAN_TAB[i];
            end
        end
        if (i < ROT_STEPS - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1] <= n_x;
                    r_y[i+1] <= n_y;
                    r_z[i+1] <= n_z;
                    r_f[i+1] <= r_f[i];
                end
            end
        end else begin : g_last
            // apply the fold on the last step: cosine changes sign
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1] <= r_f[i] ? -n_x : n_x;
                    r_y[i+1] <= n_y;
                end
            end
        end
    end

    assign o_sin = r_y[ROT_STEPS];
    assign o_cos = r_x[ROT_STEPS];

endmodule

// ===== rtl/core/tha_isqrt.sv =====
// Pipelined integer square root of a 61-bit value, one result bit per stage.
// Depends on tha_pkg.
module tha_isqrt
    import tha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_v,
    output logic [30:0] o_root
);

    logic [61:0] r_rem [ISQ_STEPS];
    logic [61:0] r_rt  [ISQ_LAT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 62'(i_v);
            r_rt[0]  <= '0;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_st
        localparam logic [61:0] BIT = 62'd1 << (2 * (ISQ_STEPS - 1 - k));
        logic [61:0] n_sum;
        logic        n_ge;
        assign n_sum = r_rt[k] + BIT;
        assign n_ge  = r_rem[k] >= n_sum;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt[k+1] <= n_ge ? (r_rt[k] >> 1) + BIT : r_rt[k] >> 1;
            end
        end
        if (k < ISQ_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_ge ? r_rem[k] - n_sum : r_rem[k];
                end
            end
        end
    end

    assign o_root = r_rt[ISQ_STEPS][30:0];

endmodule

// ===== rtl/core/tha_back.sv =====
// Back end: spherical azimuth arithmetic as one stall-together pipeline.
// Depends on tha_pkg, tha_rot and tha_isqrt.
module tha_back
    import tha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_item             i_head,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [HEAD_W-1:0] o_heading,
    output logic              o_degen
);

    logic adv;

    // input stage
    logic               r_in_v;
    t_tag               r_in_tag;
    logic signed [33:0] r_ang_b, r_ang_a, r_ang_d;
    // sin/cos stage tags
    logic               r_rv   [ROT_LAT];
    t_tag               r_rtag [ROT_LAT];
    logic signed [31:0] sb, cb, sa, ca, sd, cd;
    // multiply stages
    logic               r_m1_v, r_m2_v, r_m3_v, r_m4_v;
    t_tag               r_m1_tag, r_m2_tag, r_m3_tag, r_m4_tag;
    logic signed [63:0] r_pcc, r_pss, r_pnum, r_p2, r_m2_num, r_m3_num;
    logic signed [31:0] r_cd;
    logic signed [33:0] r_t1;
    logic signed [34:0] n_cosc_raw;
    logic signed [31:0] n_cosc, r_cosc;
    logic signed [63:0] n_sq;
    logic [60:0]        r_sq_in;
    logic [61:0]        r_absn;
    // first root
    logic               r_s1v    [ISQ_LAT];
    t_tag               r_s1tag  [ISQ_LAT];
    logic [61:0]        r_s1absn [ISQ_LAT];
    logic [30:0]        sinc;
    // divider
    t_tag               n_dtag;
    logic               r_dv   [DIV_STEPS+1];
    t_tag               r_dtag [DIV_STEPS+1];
    logic [61:0]        r_rem  [DIV_STEPS];
    logic [30:0]        r_d    [DIV_STEPS];
    logic [29:0]        r_q    [DIV_STEPS+1];
    // arcsine prep
    logic               r_r1_v, r_r2_v;
    t_tag               r_r1_tag, r_r2_tag;
    logic signed [30:0] r_sina1, r_r2_sina;
    logic signed [61:0] n_sq2;
    logic [60:0]        r_sq2_in;
    // second root
    logic               r_s2v    [ISQ_LAT];
    t_tag               r_s2tag  [ISQ_LAT];
    logic signed [30:0] r_s2sina [ISQ_LAT];
    logic [30:0]        root2;
    // vectoring
    logic               r_cv   [ROT_LAT];
    t_tag               r_ctag [ROT_LAT];
    logic signed [33:0] r_vx   [ROT_STEPS];
    logic signed [33:0] r_vy   [ROT_STEPS];
    logic signed [31:0] r_vz   [ROT_LAT];
    // output
    logic               r_out_v;
    logic [HEAD_W-1:0]  r_heading;
    logic               r_degen;
    logic signed [34:0] n_az, n_h, n_hw;
    t_tag               fin;

    // advance everything when the output register is free or being drained
    assign adv   = !r_out_v || i_ready;
    assign o_pop = adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (adv) begin
            r_in_v <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang_b  <= DEG90 - 34'(i_head.latb);
            r_ang_a  <= DEG90 - 34'(i_head.lata);
            r_ang_d  <= 34'(i_head.lonb) - 34'(i_head.lona);
            r_in_tag <= '{quad: i_head.quad, same: i_head.same,
                          zero: 1'b0, sat: 1'b0, neg: 1'b0};
        end
    end

    tha_rot u_rot_b (.i_clk(i_clk), .i_en(adv), .i_ang(r_ang_b), .o_sin(sb), .o_cos(cb));
    tha_rot u_rot_a (.i_clk(i_clk), .i_en(adv), .i_ang(r_ang_a), .o_sin(sa), .o_cos(ca));
    tha_rot u_rot_d (.i_clk(i_clk), .i_en(adv), .i_ang(r_ang_d), .o_sin(sd), .o_cos(cd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (adv) begin
            r_rv[0] <= r_in_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rtag[0] <= r_in_tag;
        end
    end
    for (genvar k = 1; k < ROT_LAT; k++) begin : g_rtag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k] <= 1'b0;
            end else if (adv) begin
                r_rv[k] <= r_rv[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rtag[k] <= r_rtag[k-1];
            end
        end
    end

    // cosC = cb*ca + (sb*sa)*cd, each product floored back to Q30
    assign n_cosc_raw = 35'(r_t1) + 35'($signed(r_p2[63:30]));
    always_comb begin
        if (n_cosc_raw > 35'sd1073741824) begin
            n_cosc = 32'sd1073741824;
        end else if (n_cosc_raw < -35'sd1073741824) begin
            n_cosc = -32'sd1073741824;
        end else begin
            n_cosc = 32'(n_cosc_raw);
        end
    end
    assign n_sq = r_cosc * r_cosc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
        end else if (adv) begin
            r_m1_v <= r_rv[ROT_LAT-1];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_tag <= r_rtag[ROT_LAT-1];
            r_pcc    <= cb * ca;
            r_pss    <= sb * sa;
            r_pnum   <= sb * sd;
            r_cd     <= cd;
            r_m2_tag <= r_m1_tag;
            r_t1     <= $signed(r_pcc[63:30]);
            r_p2     <= $signed(r_pss[61:30]) * r_cd;
            r_m2_num <= r_pnum;
            r_m3_tag <= r_m2_tag;
            r_cosc   <= n_cosc;
            r_m3_num <= r_m2_num;
            r_m4_tag <= '{quad: r_m3_tag.quad, same: r_m3_tag.same, zero: r_m3_tag.zero,
                          sat: r_m3_tag.sat, neg: r_m3_num < 0};
            r_sq_in  <= ONE_SQ - n_sq[60:0];
            r_absn   <= (r_m3_num < 0) ? 62'(-r_m3_num) : 62'(r_m3_num);
        end
    end

    tha_isqrt u_sqrt_c (.i_clk(i_clk), .i_en(adv), .i_v(r_sq_in), .o_root(sinc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v[0] <= 1'b0;
        end else if (adv) begin
            r_s1v[0] <= r_m4_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1tag[0]  <= r_m4_tag;
            r_s1absn[0] <= r_absn;
        end
    end
    for (genvar k = 1; k < ISQ_LAT; k++) begin : g_s1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s1v[k] <= 1'b0;
            end else if (adv) begin
                r_s1v[k] <= r_s1v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s1tag[k]  <= r_s1tag[k-1];
                r_s1absn[k] <= r_s1absn[k-1];
            end
        end
    end

    // flag sinC of zero and quotients of one or more before dividing
    always_comb begin
        n_dtag      = r_s1tag[ISQ_LAT-1];
        n_dtag.zero = (sinc == '0);
        n_dtag.sat  = r_s1absn[ISQ_LAT-1] >= (62'(sinc) << DIV_STEPS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_s1v[ISQ_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dtag[0] <= n_dtag;
            r_rem[0]  <= r_s1absn[ISQ_LAT-1];
            r_d[0]    <= sinc;
            r_q[0]    <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int K = DIV_STEPS - 1 - j;
        logic [61:0] n_trial;
        logic        n_ge;
        assign n_trial = 62'(r_d[j]) << K;
        assign n_ge    = r_rem[j] >= n_trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (adv) begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dtag[j+1] <= r_dtag[j];
                r_q[j+1]    <= n_ge ? r_q[j] | (30'd1 << K) : r_q[j];
            end
        end
        if (j < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rem[j+1] <= n_ge ? r_rem[j] - n_trial : r_rem[j];
                    r_d[j+1]   <= r_d[j];
                end
            end
        end
    end

    assign n_sq2 = r_sina1 * r_sina1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
            r_r2_v <= 1'b0;
        end else if (adv) begin
            r_r1_v <= r_dv[DIV_STEPS];
            r_r2_v <= r_r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r1_tag  <= r_dtag[DIV_STEPS];
            r_sina1   <= r_dtag[DIV_STEPS].neg ? -$signed({1'b0, r_q[DIV_STEPS]})
                                               : $signed({1'b0, r_q[DIV_STEPS]});
            r_r2_tag  <= r_r1_tag;
            r_r2_sina <= r_sina1;
            r_sq2_in  <= ONE_SQ - 61'(n_sq2);
        end
    end

    tha_isqrt u_sqrt_a (.i_clk(i_clk), .i_en(adv), .i_v(r_sq2_in), .o_root(root2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v[0] <= 1'b0;
        end else if (adv) begin
            r_s2v[0] <= r_r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2tag[0]  <= r_r2_tag;
            r_s2sina[0] <= r_r2_sina;
        end
    end
    for (genvar k = 1; k < ISQ_LAT; k++) begin : g_s2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s2v[k] <= 1'b0;
            end else if (adv) begin
                r_s2v[k] <= r_s2v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s2tag[k]  <= r_s2tag[k-1];
                r_s2sina[k] <= r_s2sina[k-1];
            end
        end
    end

    // arcsine as atan2(sinA, sqrt(1 - sinA^2)) by vectoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (adv) begin
            r_cv[0] <= r_s2v[ISQ_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctag[0] <= r_s2tag[ISQ_LAT-1];
            r_vx[0]   <= 34'($signed({1'b0, root2}));
            r_vy[0]   <= 34'(r_s2sina[ISQ_LAT-1]);
            r_vz[0]   <= '0;
        end
    end

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_vec
        logic signed [33:0] n_x;
        logic signed [33:0] n_y;
        logic signed [31:0] n_z;
        always_comb begin
            if (r_vy[i] > 0) begin
                n_x = r_vx[i] + (r_vy[i] >>> i);
                n_y = r_vy[i] - (r_vx[i] >>> i);
                n_z = r_vz[i] + ATAN_TAB[i];
            end else begin
                n_x = r_vx[i] - (r_vy[i] >>> i);
                n_y = r_vy[i] + (r_vx[i] >>> i);
                n_z = r_vz[i] - ATAN_TAB[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (adv) begin
                r_cv[i+1] <= r_cv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctag[i+1] <= r_ctag[i];
                r_vz[i+1]   <= n_z;
            end
        end
        if (i < ROT_STEPS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_vx[i+1] <= n_x;
                    r_vy[i+1] <= n_y;
                end
            end
        end
    end

    // clamp, quadrant rule, wrap into one turn
    always_comb begin
        fin = r_ctag[ROT_STEPS];
        if (fin.sat) begin
            n_az = fin.neg ? -35'(DEG90) : 35'(DEG90);
        end else begin
            n_az = 35'(r_vz[ROT_STEPS]);
        end
        case (fin.quad)
            QD_NE:   n_h = n_az;
            QD_NW:   n_h = 35'(DEG360) + n_az;
            default: n_h = 35'(DEG180) - n_az;
        endcase
        if (n_h < 0) begin
            n_hw = n_h + 35'(DEG360);
        end else if (n_h >= 35'(DEG360)) begin
            n_hw = n_h - 35'(DEG360);
        end else begin
            n_hw = n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_cv[ROT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_degen   <= fin.same || fin.zero;
            r_heading <= (fin.same || fin.zero) ? '0 : HEAD_W'(n_hw);
        end
    end

    assign o_valid   = r_out_v;
    assign o_heading = r_heading;
    assign o_degen   = r_degen;

endmodule

// ===== sim/trace_heading_azimuth_tb.sv =====
// Testbench for trace_heading_azimuth: drives trace points on the input stream and
// checks every heading word against a fixed-point azimuth predictor held in a class.
// Depends on tha_pkg and the trace_heading_azimuth RTL.
module trace_heading_azimuth_tb;
    import tha_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  DRAIN_CYCLES = 220;   // covers back-end latency plus queue depth
    localparam longint A90  = DEG90;
    localparam longint A180 = DEG180;
    localparam longint A360 = DEG360;
    localparam longint ONE  = 64'sd1 << 30;
    localparam longint LON_MAX = 754974720;
    localparam longint LAT_MAX = 377487360;

    typedef struct {
        logic [HEAD_W-1:0] heading;
        logic              degenerate;
    } t_heading;

    // Heading predictor: mirrors the delay line, fill count and step register.
    class heading_board;
        longint   hist_lon [MAX_STEP];
        longint   hist_lat [MAX_STEP];
        int       fill;
        int       step_reg;
        t_heading pending_headings [$];
        int       mismatches;

        function new();
            fill = 0;
            step_reg = 1;
            mismatches = 0;
            foreach (hist_lon[i]) begin
                hist_lon[i] = 0;
                hist_lat[i] = 0;
            end
        endfunction

        function automatic longint unsigned root(longint unsigned v);
            longint unsigned r = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic void rotate(longint a, output longint s, output longint c);
            longint x, y, z, dx, dy;
            bit     flip;
            x = CORDIC_GAIN;
            y = 0;
            flip = 0;
            z = a % A360;
            if (z < 0) z += A360;
            if (z > A180) z -= A360;
            if (z > A90) begin
                z = A180 - z;
                flip = 1;
            end else if (z < -A90) begin
                z = -A180 - z;
                flip = 1;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end
            end
            s = y;
            c = flip ? -x : x;
        endfunction

        function automatic longint arc_sine(longint s);
            longint x, y, z, dx, dy;
            x = longint'(root((64'd1 << 60) - s * s));
            y = s;
            z = 0;
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            return z;
        endfunction

        function automatic t_heading bearing(longint lona, longint lata,
                                             longint lonb, longint latb);
            t_heading r;
            longint sb, cb, sa, ca, sd, cd, cosc, sinc, sina, az, h;
            r.heading = '0;
            r.degenerate = 1'b1;
            if (lona == lonb && lata == latb) return r;
            rotate(A90 - latb, sb, cb);
            rotate(A90 - lata, sa, ca);
            rotate(lonb - lona, sd, cd);
            cosc = ((cb * ca) >>> 30) + ((((sb * sa) >>> 30) * cd) >>> 30);
            if (cosc > ONE) cosc = ONE;
            if (cosc < -ONE) cosc = -ONE;
            sinc = longint'(root((64'd1 << 60) - cosc * cosc));
            if (sinc == 0) return r;
            sina = (sb * sd) / sinc;
            if (sina >= ONE) az = A90;
            else if (sina <= -ONE) az = -A90;
            else az = arc_sine(sina);
            // quadrant on raw coordinates
            if (lonb > lona && latb > lata) h = az;
            else if (lonb < lona && latb > lata) h = A360 + az;
            else h = A180 - az;
            h = h % A360;
            if (h < 0) h += A360;
            r.heading = h[HEAD_W-1:0];
            r.degenerate = 1'b0;
            return r;
        endfunction

        function void note_point(logic start, logic [LON_W-1:0] lon_bits,
                                 logic [LAT_W-1:0] lat_bits);
            longint lon, lat;
            int     s;
            lon = longint'($signed(lon_bits));
            lat = longint'($signed(lat_bits));
            s = step_reg;
            if (start) fill = 0;
            if (s < 1) s = 1;
            if (s > MAX_STEP) s = MAX_STEP;
            if (fill >= s)
                pending_headings.insert(pending_headings.size(),
                                        bearing(hist_lon[s-1], hist_lat[s-1], lon, lat));
            for (int i = MAX_STEP - 1; i > 0; i--) begin
                hist_lon[i] = hist_lon[i-1];
                hist_lat[i] = hist_lat[i-1];
            end
            hist_lon[0] = lon;
            hist_lat[0] = lat;
            if (fill < MAX_STEP) fill++;
        endfunction

        function void check_heading(logic [HEAD_W-1:0] heading, logic degenerate);
            t_heading e;
            if (pending_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected heading word %0d degenerate %0b", heading, degenerate);
                return;
            end
            e = pending_headings.pop_front();
            if (e.heading !== heading || e.degenerate !== degenerate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("heading mismatch: expected %0d/%0b got %0d/%0b",
                             e.heading, e.degenerate, heading, degenerate);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata = '0;   // [30:0] longitude, [60:31] latitude, pad
    logic [0:0]       s_axis_tuser = '0;   // [0] trace_start
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;        // [30:0] heading, pad
    logic [0:0]       m_axis_tuser;        // [0] degenerate
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    heading_board board = new();
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           cycles = 0;

    trace_heading_azimuth dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hang guard: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL trace_heading_azimuth");
            $finish;
        end
    end

    // Sink: stall at random, check every word taken.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_heading(m_axis_tdata[HEAD_W-1:0], m_axis_tuser[0]);
    end

    // Offer one point; return at the edge where it is taken, then predict it.
    task automatic send_point(logic start, logic [LON_W-1:0] lon, logic [LAT_W-1:0] lat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, lat, lon};
        s_axis_tuser  <= start;
        // tready only moves after a rising edge, so the falling edge shows the handshake
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        board.note_point(start, lon, lat);
    endtask

    // Drop valid, drain the pipeline, then write the step register.
    task automatic write_step(logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending_headings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.step_reg = int'(value);
    endtask

    function automatic longint clip(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // Random traces: well-formed walks mostly, some full-range noise.
    task automatic random_traces(int count, int step);
        longint lon, lat, wlon [$], wlat [$];
        int     len, span;
        logic   start;
        span = (step < 1) ? 1 : ((step > MAX_STEP) ? MAX_STEP : step);
        while (count > 0) begin
            if ($urandom_range(99) < 8) begin
                send_point(1'($urandom_range(1)), LON_W'($urandom()), LAT_W'($urandom()));
                count--;
            end else begin
                len = $urandom_range(2 * span + 6, 1);
                lon = longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
                lat = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
                wlon.delete();
                wlat.delete();
                for (int k = 0; k < len && count > 0; k++) begin
                    start = (k == 0);
                    case ($urandom_range(9))
                        0: ;  // hold: coincident with the previous point
                        1: if (wlon.size() >= span) begin
                            lon = wlon[wlon.size() - span];
                            lat = wlat[wlat.size() - span];
                        end
                        2: begin
                            lon = longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
                            lat = longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
                        end
                        default: begin
                            lon = clip(lon + longint'($urandom_range(1 << 22)) - (1 << 21),
                                       LON_MAX);
                            lat = clip(lat + longint'($urandom_range(1 << 22)) - (1 << 21),
                                       LAT_MAX);
                        end
                    endcase
                    if (k > 0 && $urandom_range(49) == 0) start = 1'b1;
                    send_point(start, lon[LON_W-1:0], lat[LAT_W-1:0]);
                    wlon.insert(wlon.size(), lon);
                    wlat.insert(wlat.size(), lat);
                    count--;
                end
            end
        end
    endtask

    initial begin
        static int steps [9] = '{2, 16, 0, 31, 1, 17, 5, 8, 3};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at the reset step of one.
        send_point(1'b1, '0, '0);
        send_point(1'b0, '0, '0);                                   // coincident
        send_point(1'b0, 31'(LON_MAX), 30'(LAT_MAX));
        send_point(1'b0, 31'(-LON_MAX), 30'(-LAT_MAX));
        send_point(1'b0, 31'(-LON_MAX), 30'(LAT_MAX));
        send_point(1'b0, 31'(0), 30'(LAT_MAX));                     // pole, other longitude
        send_point(1'b0, 31'(A90), 30'(LAT_MAX));
        send_point(1'b0, 31'(0), 30'(0));
        send_point(1'b0, 31'(1 << 22), 30'(0));                     // east
        send_point(1'b0, 31'(0), 30'(0));                           // west
        send_point(1'b0, 31'(0), 30'(1 << 22));                     // north
        send_point(1'b0, 31'(0), 30'(0));                           // south
        send_point(1'b0, 31'(1 << 22), 30'(1 << 22));               // northeast
        send_point(1'b0, 31'(0), 30'(2 << 22));                     // northwest
        send_point(1'b0, 31'(1 << 22), 30'(1 << 22));               // southeast
        send_point(1'b0, 31'(0), 30'(0));                           // southwest
        send_point(1'b1, 31'(5 << 22), 30'(5 << 22));               // new trace, no word
        send_point(1'b0, 31'(A180), 30'(-LAT_MAX));                 // south pole
        send_point(1'b0, 31'h3FFF_FFFF, 30'h1FFF_FFFF);             // out of range
        send_point(1'b0, 31'h4000_0000, 30'h2000_0000);
        send_point(1'b0, 31'h7FFF_FFFF, 30'h3FFF_FFFF);

        foreach (steps[n]) begin
            write_step(CFG_W'(steps[n]));
            if (n < 3) begin
                send_idle_pct = 33; recv_idle_pct = 51;
            end else if (n < 6) begin
                send_idle_pct = 51; recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_traces(88, steps[n]);
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending_headings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_headings.size() == 0)
            $display("PASS trace_heading_azimuth");
        else
            $display("FAIL trace_heading_azimuth");
        $finish;
    end

endmodule
